### hdl/topp_pkg.sv
`default_nettype none

package topp_pkg;

  localparam int unsigned SCREEN_BITS = 10;
  localparam int unsigned MODE_BITS   = 9;
  localparam int unsigned LIST_DEPTH  = 3;
  localparam int unsigned TAB_STOP    = 8;

  // Register indexes on the configuration channel
  localparam logic [7:0] REG_MODE  = 8'd0;
  localparam logic [7:0] REG_ERASE = 8'd1;
  localparam logic [7:0] REG_KILL  = 8'd2;
  localparam logic [7:0] REG_COLS  = 8'd3;

  // Reset values of the registers
  localparam logic [MODE_BITS-1:0]   MODE_RESET  = 9'd493;
  localparam logic [7:0]             ERASE_RESET = 8'd127;
  localparam logic [7:0]             KILL_RESET  = 8'd21;
  localparam logic [SCREEN_BITS-1:0] COLS_RESET  = 10'd80;

  // Characters
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CTL_LIMIT  = 8'd32;
  localparam logic [7:0] CTL_OFFSET = 8'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ECHO  = 1'b1;

  // Mode flags, highest bit first
  typedef struct packed {
    logic echoctl;
    logic echoke;
    logic echok;
    logic echoe;
    logic echonl;
    logic echo;
    logic onlcr;
    logic xtabs;
    logic canon;
  } mode_flags_t;

  typedef struct packed {
    mode_flags_t            mode;
    logic [7:0]             erase_char;
    logic [7:0]             kill_char;
    logic [SCREEN_BITS-1:0] screen_cols;
  } cfg_t;

  // Characters handed to output processing for one item, in order c0, c1, c2
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } emit_list_t;

endpackage

`default_nettype wire

### hdl/terminal_output_postprocessor.sv
`default_nettype none

// Terminal output post-processor.
// Input stream (s_*): one transaction per character, s_tdata the byte,
// s_tuser set for the echo of a received byte, clear for a plain write.
// Output stream (m_*): the bytes for the terminal, one per transaction, with
// m_tlast on the final byte that an input caused. An input that yields
// nothing (end-of-transmission in canonical mode, suppressed echo) gives no
// output transaction at all.
// Configuration (cfg_*): cfg_index selects mode flags, erase, kill or screen
// width; always ready; write only while the streams are quiet.
// An accepted item goes into the input register; its first byte is then
// registered into the output register, which takes one byte per cycle.
// Throughput: one input per cycle while each yields one byte and m_tready
// does not stall; an item of N bytes holds the input register until its last
// byte leaves (tab expansion up to 8, kill echo up to 4, erase echo up to 3
// unless it expands as a tab). Reset: clears the column to zero, empties both
// registers and loads the register defaults. A stall on m_tready holds the
// output byte and, once the input register is also full, drops s_tready.
module terminal_output_postprocessor #(
  parameter int unsigned COLUMN_BITS = 10
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input stream
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] op
  // Output stream
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,
  // Configuration writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [9:0] cfg_data
);
  import topp_pkg::*;

  cfg_t       cfg;
  emit_list_t dec_list;
  logic       in_free;
  logic       in_take;

  // Register file; ignore writes beyond the four registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_RESET;
      cfg.erase_char  <= ERASE_RESET;
      cfg.kill_char   <= KILL_RESET;
      cfg.screen_cols <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:  cfg.mode        <= cfg_data[MODE_BITS-1:0];
        REG_ERASE: cfg.erase_char  <= cfg_data[7:0];
        REG_KILL:  cfg.kill_char   <= cfg_data[7:0];
        REG_COLS:  cfg.screen_cols <= cfg_data[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Take a new transaction whenever the input register is empty or retiring
  assign s_tready = in_free;
  assign in_take  = s_tvalid && s_tready;

  topp_decode u_decode (
    .op        (s_tuser),
    .data_byte (s_tdata),
    .cfg       (cfg),
    .list      (dec_list)
  );

  topp_expand #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_expand (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_take  (in_take),
    .in_list  (dec_list),
    .in_free  (in_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### hdl/topp_decode.sv
`default_nettype none

module topp_decode (
  input  wire logic               op,
  input  wire logic [7:0]         data_byte,
  input  wire topp_pkg::cfg_t     cfg,
  output topp_pkg::emit_list_t    list
);
  import topp_pkg::*;

  emit_list_t raw;

  // Render echo (erase, kill, caret notation) into at most three characters
  always_comb begin
    raw = '0;
    if (op == OP_WRITE) begin
      raw.count = 2'd1;
      raw.c0    = data_byte;
    end else if (!cfg.mode.echo) begin
      if (data_byte == CH_LF && cfg.mode.echonl) begin
        raw.count = 2'd1;
        raw.c0    = CH_LF;
      end
    end else if (cfg.mode.canon && data_byte == cfg.erase_char) begin
      if (cfg.mode.echoe) begin
        raw.count = 2'd3;
        raw.c0    = CH_BS;
        raw.c1    = CH_SPACE;
        raw.c2    = CH_BS;
      end else begin
        raw.count = 2'd1;
        raw.c0    = cfg.erase_char;
      end
    end else if (cfg.mode.canon && data_byte == cfg.kill_char) begin
      if (cfg.mode.echoke) begin
        raw.count = 2'd3;
        raw.c0    = CH_CARET;
        raw.c1    = CH_U;
        raw.c2    = CH_LF;
      end else if (cfg.mode.echok) begin
        raw.count = 2'd1;
        raw.c0    = CH_LF;
      end
    end else if (cfg.mode.echoctl && data_byte < CTL_LIMIT &&
                 data_byte != CH_LF && data_byte != CH_TAB) begin
      raw.count = 2'd2;
      raw.c0    = CH_CARET;
      raw.c1    = 8'(data_byte + CTL_OFFSET);
    end else begin
      raw.count = 2'd1;
      raw.c0    = data_byte;
    end
  end

  // Drop end-of-transmission in canonical mode; it only ever stands alone
  always_comb begin
    list = raw;
    if (raw.count == 2'd1 && raw.c0 == CH_EOT && cfg.mode.canon) begin
      list.count = 2'd0;
    end
  end

endmodule

`default_nettype wire

### hdl/topp_expand.sv
`default_nettype none

module topp_expand #(
  parameter int unsigned COLUMN_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire topp_pkg::cfg_t       cfg,
  input  wire logic                 in_take,
  input  wire topp_pkg::emit_list_t in_list,
  output logic                      in_free,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,
  output logic                      m_tlast
);
  import topp_pkg::*;

  localparam int unsigned CmpBits = (COLUMN_BITS > SCREEN_BITS) ? COLUMN_BITS : SCREEN_BITS;

  // Input register
  logic             busy;
  emit_list_t       list;
  logic [1:0]       li;
  logic             first;
  logic [3:0]       tab_left;

  // Output state
  logic [COLUMN_BITS-1:0] column;
  logic [COLUMN_BITS-1:0] column_next;
  logic [COLUMN_BITS-1:0] col_inc;

  logic [7:0] ch;
  logic       is_tab;
  logic       is_nl;
  logic [3:0] left_now;
  logic       char_done;
  logic       final_raw;
  logic [7:0] raw;
  logic       advance;
  logic       step;
  logic       retire;

  always_comb begin
    unique case (li)
      2'd0:    ch = list.c0;
      2'd1:    ch = list.c1;
      default: ch = list.c2;
    endcase
  end

  assign is_tab   = (ch == CH_TAB) && cfg.mode.xtabs;
  assign is_nl    = (ch == CH_LF) && cfg.mode.onlcr;
  assign left_now = first ? (4'(TAB_STOP) - {1'b0, column[2:0]}) : tab_left;

  always_comb begin
    priority if (is_tab) begin
      raw       = CH_SPACE;
      char_done = (left_now == 4'd1);
    end else if (is_nl) begin
      raw       = first ? CH_CR : CH_LF;
      char_done = !first;
    end else begin
      raw       = ch;
      char_done = 1'b1;
    end
  end

  assign final_raw = char_done && (li == list.count - 2'd1);
  assign advance   = !m_tvalid || m_tready;
  assign step      = busy && (list.count != 2'd0) && advance;
  assign retire    = busy && ((list.count == 2'd0) || (advance && final_raw));
  assign in_free   = !busy || retire;

  // Column after the byte leaving now
  assign col_inc = column + COLUMN_BITS'(1);

  always_comb begin
    priority if (raw == CH_CR || raw == CH_LF) begin
      column_next = '0;
    end else if (raw == CH_BS) begin
      column_next = (column != '0) ? column - COLUMN_BITS'(1) : column;
    end else if (cfg.screen_cols != '0 &&
                 CmpBits'(col_inc) >= CmpBits'(cfg.screen_cols)) begin
      column_next = '0;
    end else begin
      column_next = col_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      column   <= '0;
      li       <= 2'd0;
      first    <= 1'b1;
    end else begin
      if (in_take) begin
        busy  <= 1'b1;
        li    <= 2'd0;
        first <= 1'b1;
      end else begin
        if (retire) begin
          busy <= 1'b0;
        end
        if (step) begin
          first <= char_done;
          if (char_done) begin
            li <= li + 2'd1;
          end
        end
      end
      if (step) begin
        m_tvalid <= 1'b1;
        column   <= column_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      list <= in_list;
    end
    if (step) begin
      tab_left <= left_now - 4'd1;
      m_tdata  <= raw;
      m_tlast  <= final_raw;
    end
  end

`ifndef ASSERT_OFF
  a_index_in_list: assert property (@(posedge clk) disable iff (rst)
    busy && list.count != 2'd0 |-> li < list.count)
    else $error("character index beyond the emit list");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    step && (raw == CH_CR || raw == CH_LF) |=> column == '0)
    else $error("column not cleared after CR or LF");

  a_multi_phase: assert property (@(posedge clk) disable iff (rst)
    busy && !first |-> is_tab || is_nl)
    else $error("continuation phase on a single-byte character");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("result withdrawn without a transaction");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_terminal_output_postprocessor.sv
`timescale 1ns / 100ps

module tb_terminal_output_postprocessor;
  import topp_pkg::*;

  // Column counter width of the block under test (its default)
  localparam int unsigned COL_BITS = 10;
  // Most bytes that one input can turn into
  localparam int unsigned MAX_ITEM_BYTES = 8;
  // Cycles to let an item with no output work its way out before a register write
  localparam int unsigned SETTLE_CYCLES = 8;
  // Cycles to watch for stray output once nothing is expected any more
  localparam int unsigned END_CYCLES = 20;
  // Longest receiver hold-off asked for by the backpressure test
  localparam int unsigned RX_HOLD_CYCLES = 200;
  // Cycles with no transaction on any channel before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Stop printing mismatch lines after this many (counting goes on)
  localparam int unsigned MAX_REPORTS = 40;

  // Register indexes that address nothing
  localparam logic [7:0] REG_SPARE_LO = 8'd4;
  localparam logic [7:0] REG_SPARE_HI = 8'hFF;

  // Mode flag masks, bit order as in mode_flags_t
  localparam logic [8:0] MF_CANON   = 9'h001;
  localparam logic [8:0] MF_XTABS   = 9'h002;
  localparam logic [8:0] MF_ONLCR   = 9'h004;
  localparam logic [8:0] MF_ECHO    = 9'h008;
  localparam logic [8:0] MF_ECHONL  = 9'h010;
  localparam logic [8:0] MF_ECHOE   = 9'h020;
  localparam logic [8:0] MF_ECHOK   = 9'h040;
  localparam logic [8:0] MF_ECHOKE  = 9'h080;
  localparam logic [8:0] MF_ECHOCTL = 9'h100;
  localparam logic [8:0] MF_ALL     = 9'h1FF;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } tx_byte_t;

  // Clock, reset and block ports; every input starts at a known value
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = OP_WRITE;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = REG_MODE;
  logic [9:0] cfg_data = '0;

  // Shadow of the block's registers and column, as the predictor sees them
  mode_flags_t          cur_mode  = MODE_RESET;
  logic [7:0]           cur_erase = ERASE_RESET;
  logic [7:0]           cur_kill  = KILL_RESET;
  logic [SCREEN_BITS-1:0] cur_cols = COLS_RESET;
  logic [COL_BITS-1:0]  col_pos   = '0;

  // Bytes of the item being predicted, and every byte still owed by the block
  logic [7:0] item_bytes[$];
  tx_byte_t   tx_expected[$];

  // Idling percentages per cycle for the sender and the receiver
  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct  = 0;

  // Receiver hold-off requests: the test bumps the request count, the
  // receiver process notices and counts the stall out on its own
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  int unsigned items_sent    = 0;
  int unsigned echo_items    = 0;
  int unsigned bytes_checked = 0;
  int unsigned cfg_writes    = 0;
  int unsigned settings_used = 0;
  int unsigned error_count   = 0;

  terminal_output_postprocessor #(
    .COLUMN_BITS(COL_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] data_byte
    .s_tuser  (s_tuser),    // [0] op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [7:0] out_byte
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: output processing, echo rendering and column tracking
  // ---------------------------------------------------------------------

  // Send one raw byte to the line and move the column the way a terminal would
  function automatic void put_byte(logic [7:0] b);
    if (item_bytes.size() < MAX_ITEM_BYTES) item_bytes.push_back(b);
    if (b == CH_CR || b == CH_LF) begin
      col_pos = '0;
    end else if (b == CH_BS) begin
      if (col_pos != 0) col_pos = col_pos - 1'b1;
    end else begin
      // Natural wrap of the counter first, then the screen width
      col_pos = col_pos + 1'b1;
      if (cur_cols != 0 && col_pos >= cur_cols) col_pos = '0;
    end
  endfunction

  // Output processing of one character: drop EOT, expand tab, map newline
  function automatic void render_output(logic [7:0] b);
    int unsigned n;
    if (b == CH_EOT && cur_mode.canon) return;
    if (b == CH_TAB && cur_mode.xtabs) begin
      n = TAB_STOP - (int'(col_pos) % TAB_STOP);
      repeat (n) put_byte(CH_SPACE);
      return;
    end
    if (b == CH_LF && cur_mode.onlcr) put_byte(CH_CR);
    put_byte(b);
  endfunction

  // Echo of a received character; the erase check comes before the kill check
  function automatic void render_echo(logic [7:0] c);
    if (!cur_mode.echo) begin
      if (c == CH_LF && cur_mode.echonl) render_output(CH_LF);
      return;
    end
    if (cur_mode.canon && c == cur_erase) begin
      if (cur_mode.echoe) begin
        render_output(CH_BS);
        render_output(CH_SPACE);
        render_output(CH_BS);
      end else begin
        render_output(cur_erase);
      end
      return;
    end
    if (cur_mode.canon && c == cur_kill) begin
      if (cur_mode.echoke) begin
        render_output(CH_CARET);
        render_output(CH_U);
        render_output(CH_LF);
      end else if (cur_mode.echok) begin
        render_output(CH_LF);
      end
      return;
    end
    if (cur_mode.echoctl && c < CTL_LIMIT && c != CH_LF && c != CH_TAB) begin
      render_output(CH_CARET);
      render_output(c + CTL_OFFSET);
      return;
    end
    render_output(c);
  endfunction

  // Work out the bytes one accepted input owes and queue them, last one marked
  function automatic void predict_item(logic op, logic [7:0] c);
    item_bytes.delete();
    if (op == OP_ECHO) render_echo(c);
    else render_output(c);
    foreach (item_bytes[k])
      tx_expected.push_back('{ch: item_bytes[k], last: (k == item_bytes.size() - 1)});
  endfunction

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------

  // Drive m_tready: hold off for a counted stretch on request, else idle at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= RX_HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < MAX_REPORTS)
      $display("%0t ns: %s mismatch on output byte %0d: got %02h, expected %02h",
               $time, field, bytes_checked, got, want);
    error_count++;
  endtask

  // Compare every output transaction with the oldest byte still owed
  always @(posedge clk) begin : tx_monitor
    tx_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tx_expected.size() == 0) begin
        report_mismatch("unexpected", m_tdata, 8'h00);
      end else begin
        want = tx_expected.pop_front();
        if (m_tdata !== want.ch) report_mismatch("out_byte", m_tdata, want.ch);
        if (m_tlast !== want.last)
          report_mismatch("last", 8'(m_tlast), 8'(want.last));
      end
      bytes_checked++;
    end
  end

  // Abandon the run when no channel has moved for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t ns: no transaction for %0d cycles, %0d bytes still owed",
             $time, WATCHDOG_LIMIT, tx_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender, register writes and flow control helpers
  // ---------------------------------------------------------------------

  // Offer one character; idle at random first, and leave tvalid high on return
  // so that a following item goes out back to back
  task automatic send_item(input logic op, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_item(op, c);
    items_sent++;
    if (op == OP_ECHO) echo_items++;
  endtask

  // Stop offering and wait until every owed byte has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tx_expected.size() != 0) @(posedge clk);
  endtask

  // Drained, and let an item that gives no output leave the pipeline too
  task automatic wait_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transaction; leaves cfg_valid high for the caller to drop
  task automatic write_reg(input logic [7:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    // Bits above each register's width are ignored, unknown indexes too
    case (idx)
      REG_MODE:  cur_mode  = mode_flags_t'(val[MODE_BITS-1:0]);
      REG_ERASE: cur_erase = val[7:0];
      REG_KILL:  cur_kill  = val[7:0];
      REG_COLS:  cur_cols  = val[SCREEN_BITS-1:0];
      default: ;
    endcase
  endtask

  // Load a whole setting while the block is idle; junk goes in the unused upper
  // data bits and a write to an index that addresses nothing goes along
  task automatic set_config(input logic [8:0] mode, input logic [7:0] erase,
                            input logic [7:0] kill, input logic [9:0] cols);
    wait_quiet();
    write_reg(REG_MODE, {1'($urandom), mode});
    write_reg(REG_ERASE, {2'($urandom), erase});
    write_reg(REG_KILL, {2'($urandom), kill});
    write_reg(REG_COLS, cols);
    write_reg(8'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 10'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // A character with weight on the cases that matter to the block
  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return cur_erase;
    if (roll < 14) return cur_kill;
    if (roll < 34) begin
      case ($urandom_range(5))
        0: return CH_EOT;
        1: return CH_BS;
        2: return CH_TAB;
        3: return CH_LF;
        4: return CH_CR;
        default: return CH_SPACE;
      endcase
    end
    if (roll < 50) return 8'($urandom_range(31));
    return 8'($urandom);
  endfunction

  task automatic randomise_config();
    logic [9:0] cols;
    logic [7:0] erase;
    logic [7:0] kill;
    case ($urandom_range(4))
      0: cols = '0;
      1: cols = 10'd1;
      2: cols = 10'd1023;
      3: cols = 10'($urandom_range(24, 1));
      default: cols = 10'($urandom);
    endcase
    case ($urandom_range(3))
      0: erase = ERASE_RESET;
      1: erase = CH_BS;
      default: erase = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: kill = KILL_RESET;
      1: kill = erase;
      default: kill = 8'($urandom);
    endcase
    set_config(9'($urandom_range(MF_ALL)), erase, kill, cols);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Register defaults straight out of reset: plain writes and echo rendering
  task automatic test_reset_defaults();
    send_item(OP_WRITE, 8'h41);
    send_item(OP_WRITE, 8'h00);
    send_item(OP_WRITE, 8'hFF);
    send_item(OP_WRITE, CH_EOT);         // dropped in canonical mode
    send_item(OP_WRITE, CH_LF);          // CR goes first
    send_item(OP_WRITE, CH_TAB);         // no expansion by default
    send_item(OP_ECHO, ERASE_RESET);     // backspace, space, backspace
    send_item(OP_ECHO, KILL_RESET);      // caret, U, newline
    send_item(OP_ECHO, 8'h01);           // caret notation
    send_item(OP_ECHO, CH_EOT);          // caret notation, not dropped
    send_item(OP_ECHO, CH_LF);
    send_item(OP_ECHO, CH_TAB);
    send_item(OP_ECHO, 8'h80);
  endtask

  // Echo and output variants that need other register settings
  task automatic test_echo_variants();
    // Every flag on, erase and kill the same character, narrowest screen
    set_config(MF_ALL, CH_BS, CH_BS, 10'd1);
    send_item(OP_ECHO, CH_BS);           // erase handling wins over kill
    send_item(OP_WRITE, CH_TAB);

    // Echo off with newline echo, canonical off, no width
    set_config(MF_ECHONL, 8'hFF, 8'h00, 10'd0);
    send_item(OP_ECHO, CH_LF);
    send_item(OP_ECHO, 8'h78);           // suppressed
    send_item(OP_WRITE, CH_EOT);         // passes outside canonical mode
    send_item(OP_ECHO, 8'h00);           // suppressed

    // Plain erase echo, kill as a bare newline, no caret notation, widest screen
    set_config(MF_CANON | MF_ECHO | MF_ECHOK, ERASE_RESET, KILL_RESET, 10'd1023);
    @(posedge clk);
    write_reg(REG_SPARE_LO, 10'h3FF);
    write_reg(REG_SPARE_HI, 10'h3FF);
    cfg_valid <= 1'b0;
    send_item(OP_ECHO, ERASE_RESET);
    send_item(OP_ECHO, KILL_RESET);
    send_item(OP_ECHO, 8'h03);
    send_item(OP_ECHO, CH_EOT);          // dropped on the way out

    // Erase echoed as itself and expanded as a tab; kill echo off
    set_config(MF_CANON | MF_XTABS | MF_ECHO, CH_TAB, KILL_RESET, COLS_RESET);
    send_item(OP_ECHO, CH_TAB);
    send_item(OP_ECHO, KILL_RESET);      // nothing at all
  endtask

  // Random characters and operations over a few random settings
  task automatic test_random_traffic(input int unsigned n_settings,
                                     input int unsigned n_items);
    repeat (n_settings) begin
      randomise_config();
      repeat (n_items) send_item(1'($urandom), pick_char());
    end
  endtask

  // Run the column far enough to wrap at a wide screen, mostly with tabs
  task automatic test_long_line();
    int unsigned roll;
    set_config(MF_CANON | MF_XTABS | MF_ONLCR | MF_ECHO | MF_ECHOCTL,
               ERASE_RESET, KILL_RESET, 10'd300);
    repeat (60) begin
      roll = $urandom_range(99);
      if (roll < 92) send_item(OP_WRITE, CH_TAB);
      else if (roll < 96) send_item(OP_WRITE, 8'($urandom_range(8'h7E, 8'h21)));
      else send_item(OP_WRITE, CH_BS);
    end
  endtask

  // Hold the receiver off while tabs keep coming, so the block fills and
  // stalls its input; then pause the sender until everything is out, and follow with random characters
  task automatic test_backpressure();
    set_config(MODE_RESET | MF_XTABS, ERASE_RESET, KILL_RESET, COLS_RESET);
    hold_requests <= hold_requests + 1;
    repeat (12) send_item(OP_WRITE, CH_TAB);
    wait_drained();
    repeat (12) send_item(1'($urandom), pick_char());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles a little, receiver idles a lot
    send_idle_pct = 14;
    rcv_idle_pct  = 58;
    test_reset_defaults();
    test_echo_variants();
    test_random_traffic(2, 10);

    // And the other way round
    send_idle_pct = 58;
    rcv_idle_pct  = 14;
    test_random_traffic(2, 10);

    // No idling on either side
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    test_long_line();
    test_backpressure();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d characters (%0d echoes) over %0d register settings, %0d writes;",
             items_sent, echo_items, settings_used, cfg_writes);
    $display("checked %0d output bytes, with column wrap, tab expansion and stalls.",
             bytes_checked);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
hdl/topp_pkg.sv
hdl/topp_decode.sv
hdl/topp_expand.sv
hdl/terminal_output_postprocessor.sv
tb/sv/tb_terminal_output_postprocessor.sv
